>>> rtl/bit_field_reader_assert.svh
// ----------------------------------------------------------------------------
// bit_field_reader_assert.svh
// Assertion macros used by the bit field reader checker.
// ----------------------------------------------------------------------------
`ifndef BIT_FIELD_READER_ASSERT_SVH
`define BIT_FIELD_READER_ASSERT_SVH

// clocked check, off while reset is held
`define BFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also runs through reset
`define BFR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/bfr_pkg.sv
// ----------------------------------------------------------------------------
// bfr_pkg
// Types and constants of the bit field reader.
// ----------------------------------------------------------------------------
package bfr_pkg;

  localparam int BUFFER_BYTES   = 8;
  localparam int MAX_FIELD_BITS = 32;
  localparam int BUF_BITS       = BUFFER_BYTES * 8;
  localparam int FILL_W         = $clog2(BUFFER_BYTES + 1);
  localparam int AVAIL_W        = 7;
  localparam int VALUE_W        = 32;
  localparam int COUNT_W        = 6;

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_ALIGN = 2'd2,
    KIND_SKIP  = 2'd3
  } bfr_kind_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_SHORT      = 2'd1,
    ST_FULL       = 2'd2,
    ST_MISALIGNED = 2'd3
  } bfr_status_t;

  typedef struct packed {
    bfr_kind_t          kind;
    logic [7:0]         byte_value;
    logic               end_of_stream;
    logic [COUNT_W-1:0] bit_count;
  } bfr_item_t;

  typedef struct packed {
    logic [AVAIL_W-1:0] bits_available;
    logic               at_end;
    bfr_status_t        status;
    logic [VALUE_W-1:0] value;
  } bfr_result_t;

  // current byte always sits in the lowest byte of bytes
  typedef struct packed {
    logic [BUF_BITS-1:0] bytes;
    logic [FILL_W-1:0]   fill;
    logic [2:0]          bit_pos;
    logic                last_seen;
  } bfr_state_t;

endpackage

>>> rtl/bfr_core.sv
// ----------------------------------------------------------------------------
// bfr_core
// Next-state and result logic for one item of the bit field reader.
// ----------------------------------------------------------------------------
module bfr_core
  import bfr_pkg::*;
(
  input  bfr_state_t  cur,
  input  bfr_item_t   item,
  output bfr_state_t  nxt,
  output bfr_result_t res
);

  logic [AVAIL_W-1:0] avail;
  logic [COUNT_W-1:0] count;
  logic [VALUE_W-1:0] win;
  logic [VALUE_W-1:0] rev;
  logic [VALUE_W-1:0] read_value;
  logic [AVAIL_W-1:0] take;
  logic [AVAIL_W-1:0] total;
  logic [2:0]         drop;

  assign avail = AVAIL_W'({cur.fill, 3'b000}) - AVAIL_W'(cur.bit_pos);

  assign count = (item.bit_count > COUNT_W'(MAX_FIELD_BITS)) ?
                 COUNT_W'(MAX_FIELD_BITS) : item.bit_count;

  // bits beyond the buffered ones read as zero; first bit drawn goes to the MSB
  assign win = VALUE_W'(cur.bytes >> cur.bit_pos);

  always_comb begin
    for (int j = 0; j < VALUE_W; j++) begin
      rev[VALUE_W-1-j] = win[j] & (AVAIL_W'(j) < avail);
    end
  end

  assign read_value = rev >> (COUNT_W'(VALUE_W) - count);

  assign take  = (AVAIL_W'(count) < avail) ? AVAIL_W'(count) : avail;
  assign total = AVAIL_W'(cur.bit_pos) + take;
  assign drop  = total[5:3];

  always_comb begin
    nxt        = cur;
    res.value  = '0;
    res.status = ST_OK;
    unique case (item.kind)
      KIND_PUSH: begin
        if (cur.fill >= FILL_W'(BUFFER_BYTES) || cur.last_seen) begin
          res.status = ST_FULL;
        end else begin
          nxt.bytes[{cur.fill[2:0], 3'b000} +: 8] = item.byte_value;
          nxt.fill      = cur.fill + FILL_W'(1);
          nxt.last_seen = cur.last_seen | item.end_of_stream;
        end
      end
      KIND_READ: begin
        if (!cur.last_seen && AVAIL_W'(count) > avail) begin
          res.status = ST_SHORT;
        end else begin
          res.value   = read_value;
          nxt.bytes   = cur.bytes >> {drop, 3'b000};
          nxt.fill    = cur.fill - FILL_W'(drop);
          nxt.bit_pos = total[2:0];
        end
      end
      KIND_ALIGN: begin
        if (cur.bit_pos != 3'd0 && cur.fill != '0) begin
          nxt.bytes   = cur.bytes >> 8;
          nxt.fill    = cur.fill - FILL_W'(1);
          nxt.bit_pos = 3'd0;
        end
      end
      KIND_SKIP: begin
        priority if (cur.bit_pos != 3'd0) begin
          res.status = ST_MISALIGNED;
        end else if (cur.fill != '0) begin
          nxt.bytes = cur.bytes >> 8;
          nxt.fill  = cur.fill - FILL_W'(1);
        end else if (!cur.last_seen) begin
          res.status = ST_SHORT;
        end else begin
          // empty store at the end: nothing to do
        end
      end
      default: ;
    endcase
    res.bits_available = AVAIL_W'({nxt.fill, 3'b000}) - AVAIL_W'(nxt.bit_pos);
    res.at_end         = nxt.last_seen && (nxt.fill == '0);
  end

endmodule

>>> rtl/bit_field_reader.sv
// ----------------------------------------------------------------------------
// bit_field_reader
// Byte-fed bit field extractor, bits drawn LSB first from each byte.
// ----------------------------------------------------------------------------
// Usage:
//   in_* stream carries one request per item: in_tuser is the kind (push
//   byte, read field, align, skip byte), in_tlast marks the final pushed
//   byte, in_tdata holds the byte value and the read bit count.
//   out_* stream returns exactly one result item per request: field value,
//   bits still buffered, status on out_tuser, and out_tlast high once the
//   final byte has been drained (reads then return zero bits).
// Pipeline: input register, then result register; the state update happens
//   as the item leaves the input register.
// Throughput: 1 item per cycle while out_tready is high; the whole step is one
//   barrel shift, bit reverse and mask over an 8-byte window that always keeps
//   the current byte in its lowest slot.
// Reset: empty buffer, bit position 0, end flag clear, both stages empty.
// Stall: while out_tready is low the result holds, the input stage keeps
//   its item, and in_tready drops once that stage is occupied.
// ----------------------------------------------------------------------------
module bit_field_reader
  import bfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] byte_value, [13:8] bit_count, [15:14] zero
  input  logic [1:0]  in_tuser,   // [1:0] kind
  input  logic        in_tlast,   // end_of_stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] value, [38:32] bits_available, [39] zero
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast   // at_end
);

  // input stage
  bfr_item_t   item_r;
  logic        s1_valid_r;
  logic        s1_go;
  logic        in_go;

  // reader state
  bfr_state_t  state_r;
  bfr_state_t  state_nxt;

  // result stage
  bfr_result_t res_r;
  bfr_result_t res_nxt;
  logic        out_valid_r;

  // the input stage moves on whenever the result register is free or drains
  assign s1_go     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;
  assign in_go     = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      item_r.kind          <= bfr_kind_t'(in_tuser);
      item_r.byte_value    <= in_tdata[7:0];
      item_r.bit_count     <= in_tdata[13:8];
      item_r.end_of_stream <= in_tlast;
    end
  end

  bfr_core u_core (
    .cur  (state_r),
    .item (item_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  // control part of the state is reset; stored bytes are payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.fill      <= '0;
      state_r.bit_pos   <= '0;
      state_r.last_seen <= 1'b0;
    end else if (s1_go) begin
      state_r.bytes     <= state_nxt.bytes;
      state_r.fill      <= state_nxt.fill;
      state_r.bit_pos   <= state_nxt.bit_pos;
      state_r.last_seen <= state_nxt.last_seen;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, res_r.bits_available, res_r.value};
  assign out_tuser  = res_r.status;
  assign out_tlast  = res_r.at_end;

endmodule

>>> rtl/bfr_checker.sv
// ----------------------------------------------------------------------------
// bfr_checker
// Port-level checks on the result stream of the bit field reader.
// ----------------------------------------------------------------------------
`include "bit_field_reader_assert.svh"

module bfr_checker
  import bfr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  `BFR_ASSERT_RST(a_idle_after_reset, rst_n && !$past(rst_n) |-> !out_tvalid, "result valid right after reset")
  `BFR_ASSERT(a_hold_on_stall, out_tvalid && !out_tready |=> out_tvalid, "result dropped while stalled")
  `BFR_ASSERT(a_avail_range, out_tvalid |-> out_tdata[38:32] <= 7'(BUF_BITS), "bits_available beyond buffer size")
  `BFR_ASSERT(a_end_empty, out_tvalid && out_tlast |-> out_tdata[38:32] == 7'd0, "at_end with bits still buffered")
  `BFR_ASSERT(a_fail_zero, out_tvalid && out_tuser != ST_OK |-> out_tdata[31:0] == 32'd0, "refused item carries a value")

endmodule

bind bit_field_reader bfr_checker u_bfr_checker (.*);
